>>> rtl/core/first_fit_free_list_allocator_top_macros.svh
// Assertion macros for the allocator checker.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH

// Clocked check, masked while reset is high.
`define FFA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds across reset.
`define FFA_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/core/ffa_pkg.sv
package ffa_pkg;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOSPACE = 2'd1,
      ST_ZERO    = 2'd2,
      ST_BADPTR  = 2'd3
   } status_type;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam int SIZE_W  = 24;
   localparam int ADDR_W  = 12;
   localparam int NUNIT_W = 24;

   // classified request handed from front to back
   typedef struct packed {
      logic                func;
      status_type          pre_status;
      logic [NUNIT_W-1:0]  nunits;
      logic [ADDR_W-1:0]   hdr;
   } cmd_type;

endpackage

>>> rtl/core/ffa_if.sv
interface ffa_req_if;
   logic                       valid;
   logic                       ready;
   logic                       func;
   logic [ffa_pkg::SIZE_W-1:0] size_bytes;
   logic [ffa_pkg::ADDR_W-1:0] block_addr;

   modport source (output valid, func, size_bytes, block_addr, input ready);
   modport sink   (input valid, func, size_bytes, block_addr, output ready);
endinterface

interface ffa_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 status;
   logic [ffa_pkg::ADDR_W-1:0] granted_addr;

   modport source (output valid, status, granted_addr, input ready);
   modport sink   (input valid, status, granted_addr, output ready);
endinterface

>>> rtl/core/ffa_front.sv
module ffa_front #(
   parameter int POOL_UNITS = 4096,
   parameter int UNIT_BYTES = 16
) (
   input  logic             clock,
   input  logic             reset,
   ffa_req_if.sink          req,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output ffa_pkg::cmd_type cmd
);
   import ffa_pkg::*;

   localparam int DW = SIZE_W + 1;
   localparam int SH = DW + $clog2(UNIT_BYTES);
   localparam int MW = DW + 1;
   localparam int PW = DW + MW;
   // reciprocal rounded up; exact for every biased byte count below 2**DW
   localparam longint unsigned RECIP =
      ((64'd1 << SH) + 64'(UNIT_BYTES) - 64'd1) / 64'(UNIT_BYTES);
   localparam logic [MW-1:0] RECIP_C = MW'(RECIP);

   logic            valid_ff, valid_in;
   cmd_type         cmd_ff, cmd_in;
   logic [DW-1:0]   num;
   logic [PW-1:0]   prod;
   logic [DW-1:0]   quo;
   logic            bad_ptr;

   assign req.ready = !valid_ff;
   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

   assign bad_ptr = (req.block_addr == '0) ||
                    ((32'(req.block_addr) - 32'd1) >= 32'(POOL_UNITS));

   // ceiling divide: bias, then multiply by the reciprocal and shift
   assign num  = DW'(req.size_bytes) + DW'(UNIT_BYTES - 1);
   assign prod = PW'(num) * PW'(RECIP_C);
   assign quo  = DW'(prod >> SH);

   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      if (valid_ff && cmd_ready) begin
         valid_in = 1'b0;
      end
      if (req.valid && req.ready) begin
         cmd_in.func       = req.func;
         cmd_in.hdr        = req.block_addr - ADDR_W'(1);
         cmd_in.nunits     = '0;
         cmd_in.pre_status = ST_OK;
         valid_in          = 1'b1;
         if (req.func == FUNC_FREE) begin
            if (bad_ptr) begin
               cmd_in.pre_status = ST_BADPTR;
            end
         end else if (req.size_bytes == '0) begin
            cmd_in.pre_status = ST_ZERO;
         end else begin
            cmd_in.nunits = NUNIT_W'(quo) + NUNIT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

>>> rtl/core/ffa_queue.sv
module ffa_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  ffa_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output ffa_pkg::cmd_type pop_cmd
);
   import ffa_pkg::*;

   cmd_type    slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_cmd    = slot_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wptr_in = wptr_ff ^ do_push;
      rptr_in = rptr_ff ^ do_pop;
      cnt_in  = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (do_push) begin
         slot_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/core/ffa_back.sv
module ffa_back #(
   parameter int POOL_UNITS = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  ffa_pkg::cmd_type cmd,
   ffa_rsp_if.source        rsp
);
   import ffa_pkg::*;

   localparam int AW = $clog2(POOL_UNITS);
   localparam int IW = $clog2(POOL_UNITS + 1);
   localparam int SW = IW + 1;
   localparam int CW = ((IW > NUNIT_W) ? IW : NUNIT_W) + 1;
   localparam int TW = $clog2(POOL_UNITS + 4);
   localparam logic [IW-1:0] SENT = IW'(POOL_UNITS);

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_AROVER = 13'b0000000000010,
      S_ALINK  = 13'b0000000000100,
      S_AFETCH = 13'b0000000001000,
      S_AEVAL  = 13'b0000000010000,
      S_ASPLIT = 13'b0000000100000,
      S_FFETCH = 13'b0000001000000,
      S_FEVAL  = 13'b0000010000000,
      S_HFETCH = 13'b0000100000000,
      S_HEVAL  = 13'b0001000000000,
      S_NEVAL  = 13'b0010000000000,
      S_W1     = 13'b0100000000000,
      S_W2     = 13'b1000000000000
   } state_type;

   logic [IW-1:0] units_mem [POOL_UNITS];
   logic [IW-1:0] link_mem  [POOL_UNITS];

   state_type     state_ff, state_in;
   logic          done_ff, done_in;
   cmd_type       cmd_ff, cmd_in;
   logic [IW-1:0] p_ff, p_in, prev_ff, prev_in, n_ff, n_in;
   logic [IW-1:0] rover_ff, rover_in, sent_ff, sent_in;
   logic [IW-1:0] up_ff, up_in, uh_ff, uh_in, lnk_ff, lnk_in;
   logic [TW-1:0] steps_ff, steps_in;
   status_type    res_st_ff, res_st_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_st_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic          u0_init_ff, l0_init_ff, rd_sent_ff, rd_zero_ff;
   logic [IW-1:0] units_rd_ff, link_rd_ff;

   logic [IW-1:0] rd_node, u_eff, l_eff, hdr, t_idx, u_minus_n;
   logic          u_we, l_we;
   logic [IW-1:0] u_wa, u_wd, l_wa, l_wd;
   logic          fit, p_sent, brk, adj_hn, adj_ph;
   logic [SW-1:0] kb, kp, kn;
   logic          can_emit;

   assign hdr       = IW'(cmd_ff.hdr);
   assign p_sent    = (p_ff >= SENT);
   assign can_emit  = !rsp_valid_ff || rsp.ready;
   assign cmd_ready = (state_ff == S_IDLE) && !done_ff;

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_st_ff;
   assign rsp.granted_addr = rsp_addr_ff;

   // read port: block 0 holds its reset value until first written
   always_comb begin
      case (state_ff)
         S_HFETCH: rd_node = hdr;
         S_HEVAL:  rd_node = n_ff;
         default:  rd_node = p_ff;
      endcase
   end

   assign u_eff = rd_sent_ff ? '0 :
                  ((rd_zero_ff && u0_init_ff) ? SENT : units_rd_ff);
   assign l_eff = rd_sent_ff ? sent_ff :
                  ((rd_zero_ff && l0_init_ff) ? SENT : link_rd_ff);

   assign fit = !p_sent && (CW'(u_eff) >= CW'(cmd_ff.nunits)) &&
                (SW'(p_ff) + SW'(u_eff) <= SW'(POOL_UNITS));
   assign u_minus_n = IW'(CW'(u_eff) - CW'(cmd_ff.nunits));
   assign t_idx     = p_ff + u_minus_n;

   assign kb = SW'(hdr) + SW'(1);
   assign kp = p_sent ? '0 : SW'(p_ff) + SW'(1);
   assign kn = (l_eff >= SENT) ? '0 : SW'(l_eff) + SW'(1);
   assign brk = ((kb > kp) && (kb < kn)) || ((kp >= kn) && ((kb > kp) || (kb < kn)));

   assign adj_hn = (n_ff < SENT) && (SW'(hdr) + SW'(u_eff) == SW'(n_ff));
   assign adj_ph = !p_sent && (SW'(p_ff) + SW'(up_ff) == SW'(hdr));

   always_comb begin
      state_in     = state_ff;
      done_in      = done_ff;
      cmd_in       = cmd_ff;
      p_in         = p_ff;
      prev_in      = prev_ff;
      n_in         = n_ff;
      rover_in     = rover_ff;
      sent_in      = sent_ff;
      up_in        = up_ff;
      uh_in        = uh_ff;
      lnk_in       = lnk_ff;
      steps_in     = steps_ff;
      res_st_in    = res_st_ff;
      res_addr_in  = res_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      u_we = 1'b0;  u_wa = '0;  u_wd = '0;
      l_we = 1'b0;  l_wa = '0;  l_wd = '0;

      if (done_ff && can_emit) begin
         done_in      = 1'b0;
         rsp_valid_in = 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               cmd_in      = cmd;
               p_in        = rover_ff;
               prev_in     = rover_ff;
               steps_in    = '0;
               res_addr_in = '0;
               res_st_in   = cmd.pre_status;
               if (cmd.pre_status != ST_OK) begin
                  done_in = 1'b1;
               end else if (cmd.func == FUNC_ALLOC) begin
                  state_in = S_AROVER;
               end else begin
                  state_in = S_FFETCH;
               end
            end
         end
         S_AROVER: state_in = S_ALINK;
         S_ALINK: begin
            p_in     = l_eff;
            state_in = S_AFETCH;
         end
         S_AFETCH: state_in = S_AEVAL;
         S_AEVAL: begin
            if (fit) begin
               rover_in = prev_ff;
               if (CW'(u_eff) == CW'(cmd_ff.nunits)) begin
                  l_we        = 1'b1;
                  l_wa        = prev_ff;
                  l_wd        = l_eff;
                  res_addr_in = ADDR_W'(SW'(p_ff) + SW'(1));
                  done_in     = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  u_we        = 1'b1;
                  u_wa        = p_ff;
                  u_wd        = u_minus_n;
                  n_in        = t_idx;
                  res_addr_in = ADDR_W'(SW'(t_idx) + SW'(1));
                  state_in    = S_ASPLIT;
               end
            end else if (p_ff == rover_ff ||
                         (TW'(steps_ff + TW'(1)) > TW'(POOL_UNITS + 2))) begin
               res_st_in = ST_NOSPACE;
               done_in   = 1'b1;
               state_in  = S_IDLE;
            end else begin
               prev_in  = p_ff;
               p_in     = l_eff;
               steps_in = steps_ff + TW'(1);
               state_in = S_AFETCH;
            end
         end
         S_ASPLIT: begin
            // write the header of the tail handed out
            u_we     = 1'b1;
            u_wa     = n_ff;
            u_wd     = IW'(cmd_ff.nunits);
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         S_FFETCH: state_in = S_FEVAL;
         S_FEVAL: begin
            if (brk) begin
               n_in     = l_eff;
               up_in    = u_eff;
               state_in = S_HFETCH;
            end else if (TW'(steps_ff + TW'(1)) > TW'(POOL_UNITS + 2)) begin
               res_st_in = ST_BADPTR;
               done_in   = 1'b1;
               state_in  = S_IDLE;
            end else begin
               p_in     = l_eff;
               steps_in = steps_ff + TW'(1);
               state_in = S_FFETCH;
            end
         end
         S_HFETCH: state_in = S_HEVAL;
         S_HEVAL: begin
            uh_in  = u_eff;
            lnk_in = n_ff;
            state_in = adj_hn ? S_NEVAL : S_W1;
         end
         S_NEVAL: begin
            // absorb the upper neighbor
            uh_in    = uh_ff + u_eff;
            lnk_in   = l_eff;
            state_in = S_W1;
         end
         S_W1: begin
            u_we = 1'b1;  u_wa = hdr;  u_wd = uh_ff;
            l_we = 1'b1;  l_wa = hdr;  l_wd = lnk_ff;
            state_in = S_W2;
         end
         S_W2: begin
            l_we = 1'b1;
            l_wa = p_ff;
            if (adj_ph) begin
               u_we = 1'b1;
               u_wa = p_ff;
               u_wd = up_ff + uh_ff;
               l_wd = lnk_ff;
            end else begin
               l_wd = hdr;
            end
            rover_in = p_ff;
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      if (l_we && l_wa >= SENT) begin
         sent_in = l_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rover_ff     <= SENT;
         sent_ff      <= '0;
         u0_init_ff   <= 1'b1;
         l0_init_ff   <= 1'b1;
      end else begin
         state_ff     <= state_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         rover_ff     <= rover_in;
         sent_ff      <= sent_in;
         if (u_we && u_wa == '0) begin
            u0_init_ff <= 1'b0;
         end
         if (l_we && l_wa == '0) begin
            l0_init_ff <= 1'b0;
         end
      end
      cmd_ff      <= cmd_in;
      p_ff        <= p_in;
      prev_ff     <= prev_in;
      n_ff        <= n_in;
      up_ff       <= up_in;
      uh_ff       <= uh_in;
      lnk_ff      <= lnk_in;
      steps_ff    <= steps_in;
      res_st_ff   <= res_st_in;
      res_addr_ff <= res_addr_in;
      if (done_ff && can_emit) begin
         rsp_st_ff   <= res_st_ff;
         rsp_addr_ff <= res_addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      units_rd_ff <= units_mem[rd_node[AW-1:0]];
      link_rd_ff  <= link_mem[rd_node[AW-1:0]];
      rd_sent_ff  <= (rd_node >= SENT);
      rd_zero_ff  <= (rd_node == '0);
      if (u_we && u_wa < SENT) begin
         units_mem[u_wa[AW-1:0]] <= u_wd;
      end
      if (l_we && l_wa < SENT) begin
         link_mem[l_wa[AW-1:0]] <= l_wd;
      end
   end

endmodule

>>> rtl/core/first_fit_free_list_allocator_top.sv
// First-fit free-list allocator over POOL_UNITS units of UNIT_BYTES bytes.
// Each request is an allocate (func 0, size_bytes) or a free (func 1,
// block_addr = payload unit, header one unit below). One response beat per
// request, in order: status 0 ok, 1 no space, 2 zero size, 3 bad pointer.
// The front end takes a beat, classifies it and turns the byte count into
// units with a reciprocal multiply in the same cycle; a two-entry queue
// then feeds the back end, which walks the address-ordered circular free
// list in two memories (sizes and links, one read and one write a cycle).
// The front end and the queue each register a request on its way to the
// back end. The back end reads each list node it visits, then evaluates
// it, so latency grows with fragmentation. The pool comes up as one free
// block right out of reset; no set-up pass is needed. Responses sit in an
// output register, so the next request can start its walk while the sink
// stalls.
module first_fit_free_list_allocator_top #(
   parameter int POOL_UNITS = 4096,
   parameter int UNIT_BYTES = 16
) (
   input  logic     clock,
   input  logic     reset,
   ffa_req_if.sink  req_if,
   ffa_rsp_if.source rsp_if
);
   import ffa_pkg::*;

   logic    f2q_valid, f2q_ready, q2b_valid, q2b_ready;
   cmd_type f2q_cmd, q2b_cmd;

   // classify and size each request beat
   ffa_front #(
      .POOL_UNITS (POOL_UNITS),
      .UNIT_BYTES (UNIT_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .cmd_valid (f2q_valid),
      .cmd_ready (f2q_ready),
      .cmd       (f2q_cmd)
   );

   // decouple front and back so each can stall alone
   ffa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f2q_valid),
      .push_ready (f2q_ready),
      .push_cmd   (f2q_cmd),
      .pop_valid  (q2b_valid),
      .pop_ready  (q2b_ready),
      .pop_cmd    (q2b_cmd)
   );

   // walk the free list and update it
   ffa_back #(
      .POOL_UNITS (POOL_UNITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q2b_valid),
      .cmd_ready (q2b_ready),
      .cmd       (q2b_cmd),
      .rsp       (rsp_if)
   );

endmodule

>>> rtl/core/ffa_checker.sv
`include "first_fit_free_list_allocator_top_macros.svh"

module ffa_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [11:0] rsp_granted
);
   import ffa_pkg::*;

   `FFA_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_granted), "stalled response beat changed")
   `FFA_ASSERT(a_fail_no_addr, rsp_valid && rsp_status != ST_OK |-> rsp_granted == 12'd0, "failed request carries an address")
   `FFA_ASSERT_RST(a_reset_quiet, reset |=> !rsp_valid, "response beat right after reset")

endmodule

bind first_fit_free_list_allocator_top ffa_port_checker u_ffa_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_status  (rsp_if.status),
   .rsp_granted (rsp_if.granted_addr)
);
